### design/two_sat_solver_macros.svh
// ----------------------------------------------------------------------------
// two_sat_solver_macros.svh
// Assertion macros used by the solver core RTL.
// ----------------------------------------------------------------------------
`ifndef TWO_SAT_SOLVER_MACROS_SVH
`define TWO_SAT_SOLVER_MACROS_SVH

// same-cycle implication, disabled in reset
`define TSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared constants, sequencer states and edge-match struct for the solver.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

    localparam int MAX_VARS_DEF    = 32;
    localparam int MAX_CLAUSES_DEF = 256;
    localparam int VAR_W           = 5;
    localparam int CNT_W           = 6;
    localparam int CLAUSE_W        = 12;
    localparam int IN_DATA_W       = 16;
    localparam int OUT_DATA_W      = 8;

    localparam logic [CNT_W-1:0] VAR_COUNT_RST = 6'd32;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_SOLVE = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_F_NODE,
        S_F_RD,
        S_F_EV,
        S_F_POP,
        S_R_ROOT,
        S_R_ROOTW,
        S_R_RD,
        S_R_EV,
        S_R_POP,
        S_C1,
        S_C2,
        S_C3,
        S_E1,
        S_E2,
        S_E3,
        S_EW
    } state_t;

    typedef struct packed {
        logic fwd_hit;
        logic rev_hit;
    } edge_hit_t;

endpackage

`default_nettype wire

### design/tss_clause_store.sv
// ----------------------------------------------------------------------------
// tss_clause_store
// Clause memory with fill count and overflow flag; registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_clause_store #(
    parameter int MAX_CLAUSES = tss_pkg::MAX_CLAUSES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 wr_en,
    input  wire logic [tss_pkg::CLAUSE_W-1:0]         wr_data,
    input  wire logic                                 clear,
    input  wire logic [$clog2(MAX_CLAUSES)-1:0]       rd_addr,
    output logic      [tss_pkg::CLAUSE_W-1:0]         rd_data,
    output logic      [$clog2(MAX_CLAUSES+1)-1:0]     total,
    output logic                                      overflow
);

    localparam int CI_W = $clog2(MAX_CLAUSES);
    localparam int TW   = $clog2(MAX_CLAUSES+1);

    logic [tss_pkg::CLAUSE_W-1:0] mem [MAX_CLAUSES];
    logic [tss_pkg::CLAUSE_W-1:0] rd_data_reg;
    logic [TW-1:0]                total_reg, total_next;
    logic                         ovf_reg, ovf_next;
    logic                         has_room;
    logic                         do_write;

    assign has_room = total_reg < TW'(MAX_CLAUSES);
    assign do_write = wr_en && has_room;

    always_comb
    begin
        total_next = total_reg;
        ovf_next   = ovf_reg;
        if (clear)
        begin
            total_next = '0;
            ovf_next   = 1'b0;
        end
        else if (wr_en)
        begin
            if (has_room)
                total_next = total_reg + TW'(1);
            else
                ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[total_reg[CI_W-1:0]] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign total    = total_reg;
    assign overflow = ovf_reg;

endmodule

`default_nettype wire

### design/tss_edge_unit.sv
// ----------------------------------------------------------------------------
// tss_edge_unit
// Decodes one implication edge of a clause and matches it against a node.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_edge_unit #(
    parameter int MAX_VARS = tss_pkg::MAX_VARS_DEF
) (
    input  wire logic [tss_pkg::CLAUSE_W-1:0]      clause,
    input  wire logic                              sel,
    input  wire logic [$clog2(MAX_VARS+1)-1:0]     n,
    input  wire logic [$clog2(2*MAX_VARS)-1:0]     node,
    output logic      [$clog2(2*MAX_VARS)-1:0]     src,
    output logic      [$clog2(2*MAX_VARS)-1:0]     dst,
    output tss_pkg::edge_hit_t                     hit
);

    localparam int NODE_W = $clog2(2*MAX_VARS);

    logic [tss_pkg::VAR_W-1:0] a, b;
    logic                      va, vb;
    logic                      live;
    logic [NODE_W-1:0]         a_n, b_n, n_n;
    logic [NODE_W-1:0]         a_t, a_f, b_t, b_f;

    assign a  = clause[11:7];
    assign va = clause[6];
    assign b  = clause[5:1];
    assign vb = clause[0];

    assign live = ({1'b0, a} < tss_pkg::CNT_W'(n)) && ({1'b0, b} < tss_pkg::CNT_W'(n));

    assign a_n = NODE_W'(a);
    assign b_n = NODE_W'(b);
    assign n_n = NODE_W'(n);
    // literal node: var for "is 1", var+n for "is 0"
    assign a_t = va ? a_n + n_n : a_n;
    assign a_f = va ? a_n : a_n + n_n;
    assign b_t = vb ? b_n + n_n : b_n;
    assign b_f = vb ? b_n : b_n + n_n;

    always_comb
    begin
        if (!sel)
        begin
            src = a_t;
            dst = b_f;
        end
        else
        begin
            src = b_t;
            dst = a_f;
        end
        hit.fwd_hit = live && (src == node);
        hit.rev_hit = live && (dst == node);
    end

endmodule

`default_nettype wire

### design/tss_scc_core.sv
// ----------------------------------------------------------------------------
// tss_scc_core
// Sequencer for the Kosaraju passes, the variable check and result output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_sat_solver_macros.svh"

module tss_scc_core #(
    parameter int MAX_VARS    = tss_pkg::MAX_VARS_DEF,
    parameter int MAX_CLAUSES = tss_pkg::MAX_CLAUSES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic [tss_pkg::CNT_W-1:0]            var_count,
    input  wire logic [$clog2(MAX_CLAUSES+1)-1:0]     clause_total,
    input  wire logic                                 overflow,
    input  wire logic [tss_pkg::CLAUSE_W-1:0]         clause_data,
    output logic      [$clog2(MAX_CLAUSES)-1:0]       clause_addr,
    output logic                                      store_clear,
    output logic                                      idle,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [tss_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                      m_tlast
);

    localparam int NODES   = 2*MAX_VARS;
    localparam int NODE_W  = $clog2(NODES);
    localparam int NVW     = $clog2(MAX_VARS+1);
    localparam int C2W     = NVW+1;
    localparam int TW      = $clog2(MAX_CLAUSES+1);
    localparam int PW      = TW+1;
    localparam int CI_W    = $clog2(MAX_CLAUSES);
    localparam int FRAME_W = NODE_W+PW;
    localparam int DEPTH_W = NODE_W+1;

    tss_pkg::state_t state_reg, state_next;

    logic [NVW-1:0]     n_reg, n_next;
    logic [C2W-1:0]     cnt_reg, cnt_next;
    logic [C2W-1:0]     idx_reg, idx_next;
    logic [C2W-1:0]     comp_reg, comp_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [NODES-1:0]   visited_reg, visited_next;
    logic [NODES-1:0]   assigned_reg, assigned_next;
    logic               sat_reg, sat_next;
    logic [NODE_W-1:0]  lo_reg, lo_next;
    logic               out_valid_reg, out_valid_next;
    logic [tss_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;

    logic [FRAME_W-1:0] stack_mem [NODES];
    logic [NODE_W-1:0]  fin_mem   [NODES];
    logic [NODE_W-1:0]  comp_mem  [NODES];
    logic [FRAME_W-1:0] stack_rd_reg;
    logic [NODE_W-1:0]  fin_rd_reg;
    logic [NODE_W-1:0]  comp_rd_reg;

    logic               stack_we, fin_we, comp_we;
    logic [NODE_W-1:0]  stack_waddr, stack_raddr;
    logic [FRAME_W-1:0] stack_wdata;
    logic [NODE_W-1:0]  fin_waddr, fin_wdata, fin_raddr;
    logic [NODE_W-1:0]  comp_waddr, comp_wdata, comp_raddr;

    logic [C2W-1:0]     nodes;
    logic [PW-1:0]      edge_total;
    logic [PW-1:0]      pos_inc;
    logic [NODE_W-1:0]  cnt_node;
    logic [NODE_W-1:0]  cnt_neg;
    logic [NODE_W-1:0]  e_src, e_dst;
    logic [NVW-1:0]     n_eff;
    tss_pkg::edge_hit_t e_hit;

    assign nodes      = {n_reg, 1'b0};
    assign edge_total = {clause_total, 1'b0};
    assign pos_inc    = pos_reg + PW'(1);
    assign cnt_node   = cnt_reg[NODE_W-1:0];
    assign cnt_neg    = NODE_W'(cnt_reg + C2W'(n_reg));
    assign clause_addr = pos_reg[CI_W:1];

    always_comb
    begin
        if (var_count == '0)
            n_eff = NVW'(1);
        else if (var_count > tss_pkg::CNT_W'(MAX_VARS))
            n_eff = NVW'(MAX_VARS);
        else
            n_eff = NVW'(var_count);
    end

    tss_edge_unit #(
        .MAX_VARS (MAX_VARS)
    ) u_edge (
        .clause (clause_data),
        .sel    (pos_reg[0]),
        .n      (n_reg),
        .node   (node_reg),
        .src    (e_src),
        .dst    (e_dst),
        .hit    (e_hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        comp_next      = comp_reg;
        depth_next     = depth_reg;
        node_next      = node_reg;
        pos_next       = pos_reg;
        visited_next   = visited_reg;
        assigned_next  = assigned_reg;
        sat_next       = sat_reg;
        lo_next        = lo_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        stack_we       = 1'b0;
        stack_waddr    = NODE_W'(depth_reg - DEPTH_W'(1));
        stack_wdata    = {node_reg, pos_inc};
        stack_raddr    = NODE_W'(depth_reg - DEPTH_W'(2));
        fin_we         = 1'b0;
        fin_waddr      = idx_reg[NODE_W-1:0];
        fin_wdata      = node_reg;
        fin_raddr      = NODE_W'(cnt_reg - C2W'(1));
        comp_we        = 1'b0;
        comp_waddr     = e_src;
        comp_wdata     = comp_reg[NODE_W-1:0];
        comp_raddr     = cnt_node;
        store_clear    = 1'b0;

        unique case (state_reg)
            tss_pkg::S_IDLE:
            begin
                if (start)
                begin
                    n_next        = n_eff;
                    cnt_next      = '0;
                    idx_next      = '0;
                    depth_next    = '0;
                    visited_next  = '0;
                    assigned_next = '0;
                    state_next    = tss_pkg::S_F_NODE;
                end
            end
            // forward pass: finish order
            tss_pkg::S_F_NODE:
            begin
                if (cnt_reg == nodes)
                begin
                    comp_next  = '0;
                    state_next = tss_pkg::S_R_ROOT;
                end
                else if (visited_reg[cnt_node])
                    cnt_next = cnt_reg + C2W'(1);
                else
                begin
                    visited_next[cnt_node] = 1'b1;
                    node_next  = cnt_node;
                    pos_next   = '0;
                    depth_next = DEPTH_W'(1);
                    state_next = tss_pkg::S_F_RD;
                end
            end
            tss_pkg::S_F_RD:
            begin
                if (pos_reg == edge_total)
                begin
                    fin_we   = 1'b1;
                    idx_next = idx_reg + C2W'(1);
                    depth_next = depth_reg - DEPTH_W'(1);
                    if (depth_reg == DEPTH_W'(1))
                    begin
                        cnt_next   = cnt_reg + C2W'(1);
                        state_next = tss_pkg::S_F_NODE;
                    end
                    else
                        state_next = tss_pkg::S_F_POP;
                end
                else
                    state_next = tss_pkg::S_F_EV;
            end
            tss_pkg::S_F_EV:
            begin
                pos_next   = pos_inc;
                state_next = tss_pkg::S_F_RD;
                if (e_hit.fwd_hit && !visited_reg[e_dst])
                begin
                    visited_next[e_dst] = 1'b1;
                    stack_we   = 1'b1;
                    node_next  = e_dst;
                    pos_next   = '0;
                    depth_next = depth_reg + DEPTH_W'(1);
                end
            end
            tss_pkg::S_F_POP:
            begin
                {node_next, pos_next} = stack_rd_reg;
                state_next = tss_pkg::S_F_RD;
            end
            // reverse pass: component numbers
            tss_pkg::S_R_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    sat_next   = 1'b1;
                    state_next = tss_pkg::S_C1;
                end
                else
                begin
                    cnt_next   = cnt_reg - C2W'(1);
                    state_next = tss_pkg::S_R_ROOTW;
                end
            end
            tss_pkg::S_R_ROOTW:
            begin
                if (assigned_reg[fin_rd_reg])
                    state_next = tss_pkg::S_R_ROOT;
                else
                begin
                    assigned_next[fin_rd_reg] = 1'b1;
                    comp_we    = 1'b1;
                    comp_waddr = fin_rd_reg;
                    node_next  = fin_rd_reg;
                    pos_next   = '0;
                    depth_next = DEPTH_W'(1);
                    state_next = tss_pkg::S_R_RD;
                end
            end
            tss_pkg::S_R_RD:
            begin
                if (pos_reg == edge_total)
                begin
                    depth_next = depth_reg - DEPTH_W'(1);
                    if (depth_reg == DEPTH_W'(1))
                    begin
                        comp_next  = comp_reg + C2W'(1);
                        state_next = tss_pkg::S_R_ROOT;
                    end
                    else
                        state_next = tss_pkg::S_R_POP;
                end
                else
                    state_next = tss_pkg::S_R_EV;
            end
            tss_pkg::S_R_EV:
            begin
                pos_next   = pos_inc;
                state_next = tss_pkg::S_R_RD;
                if (e_hit.rev_hit && !assigned_reg[e_src])
                begin
                    assigned_next[e_src] = 1'b1;
                    comp_we    = 1'b1;
                    stack_we   = 1'b1;
                    node_next  = e_src;
                    pos_next   = '0;
                    depth_next = depth_reg + DEPTH_W'(1);
                end
            end
            tss_pkg::S_R_POP:
            begin
                {node_next, pos_next} = stack_rd_reg;
                state_next = tss_pkg::S_R_RD;
            end
            // satisfiability check
            tss_pkg::S_C1:
            begin
                if (cnt_reg == C2W'(n_reg))
                begin
                    cnt_next   = '0;
                    state_next = tss_pkg::S_E1;
                end
                else
                    state_next = tss_pkg::S_C2;
            end
            tss_pkg::S_C2:
            begin
                lo_next    = comp_rd_reg;
                comp_raddr = cnt_neg;
                state_next = tss_pkg::S_C3;
            end
            tss_pkg::S_C3:
            begin
                if (lo_reg == comp_rd_reg)
                    sat_next = 1'b0;
                cnt_next   = cnt_reg + C2W'(1);
                state_next = tss_pkg::S_C1;
            end
            // result output
            tss_pkg::S_E1:
            begin
                state_next = tss_pkg::S_E2;
            end
            tss_pkg::S_E2:
            begin
                lo_next    = comp_rd_reg;
                comp_raddr = cnt_neg;
                state_next = tss_pkg::S_E3;
            end
            tss_pkg::S_E3:
            begin
                out_valid_next = 1'b1;
                out_data_next  = {overflow, sat_reg, sat_reg && (lo_reg > comp_rd_reg),
                                  tss_pkg::VAR_W'(cnt_reg)};
                out_last_next  = (cnt_reg + C2W'(1)) == C2W'(n_reg);
                state_next     = tss_pkg::S_EW;
            end
            tss_pkg::S_EW:
            begin
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        store_clear = 1'b1;
                        state_next  = tss_pkg::S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + C2W'(1);
                        state_next = tss_pkg::S_E1;
                    end
                end
            end
            default:
            begin
                state_next = tss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tss_pkg::S_IDLE;
            n_reg         <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            comp_reg      <= '0;
            depth_reg     <= '0;
            visited_reg   <= '0;
            assigned_reg  <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            comp_reg      <= comp_next;
            depth_reg     <= depth_next;
            visited_reg   <= visited_next;
            assigned_reg  <= assigned_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        pos_reg      <= pos_next;
        lo_reg       <= lo_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        stack_rd_reg <= stack_mem[stack_raddr];
        if (fin_we)
            fin_mem[fin_waddr] <= fin_wdata;
        fin_rd_reg <= fin_mem[fin_raddr];
        if (comp_we)
            comp_mem[comp_waddr] <= comp_wdata;
        comp_rd_reg <= comp_mem[comp_raddr];
    end

    assign idle     = state_reg == tss_pkg::S_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `TSS_ASSERT_IMPL(a_out_only_in_wait, clk, rst_n, out_valid_reg, state_reg == tss_pkg::S_EW, "result shown outside output wait")
    `TSS_ASSERT_IMPL(a_depth_bound, clk, rst_n, 1'b1, depth_reg <= DEPTH_W'(NODES), "walk stack overrun")
    `TSS_ASSERT_NEXT(a_last_to_idle, clk, rst_n, out_valid_reg && m_tready && out_last_reg, state_reg == tss_pkg::S_IDLE, "no return to idle after last result")
    `TSS_ASSERT_IMPL(a_idle_clean, clk, rst_n, state_reg == tss_pkg::S_IDLE, !out_valid_reg && depth_reg == '0, "idle with work pending")

endmodule

`default_nettype wire

### design/two_sat_solver.sv
// ----------------------------------------------------------------------------
// two_sat_solver
// 2-SAT clause loader and Kosaraju SCC solver with per-variable results.
// ----------------------------------------------------------------------------
// An add transaction (tuser 0) stores one clause, or sets the overflow flag
// when the store is full. A solve transaction (tuser 1) runs two depth-first
// passes over the implication graph; each edge visit is one clause memory
// read. Then each variable is checked and its result emitted. s_tready is low
// until the last result is taken. The clause store empties after every solve.
`default_nettype none

module two_sat_solver #(
    parameter int MAX_VARS    = tss_pkg::MAX_VARS_DEF,
    parameter int MAX_CLAUSES = tss_pkg::MAX_CLAUSES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tss_pkg::CNT_W-1:0]          cfg_data,   // var_count
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // first_var[4:0], first_value[5], second_var[10:6], second_value[11]
    input  wire logic [tss_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire logic                               s_tuser,    // kind
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // var_index[4:0], var_value[5], satisfiable[6], clause_overflow[7]
    output logic      [tss_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                    m_tlast
);

    localparam int CI_W = $clog2(MAX_CLAUSES);
    localparam int TW   = $clog2(MAX_CLAUSES+1);

    logic [tss_pkg::CNT_W-1:0]    var_count_reg;
    logic                         in_fire;
    logic                         add_en;
    logic                         solve_en;
    logic [tss_pkg::CLAUSE_W-1:0] clause_word;
    logic [tss_pkg::CLAUSE_W-1:0] clause_rd;
    logic [CI_W-1:0]              clause_addr;
    logic [TW-1:0]                clause_total;
    logic                         overflow;
    logic                         store_clear;
    logic                         idle;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            var_count_reg <= tss_pkg::VAR_COUNT_RST;
        else if (cfg_valid)
            var_count_reg <= cfg_data;
    end

    assign s_tready    = idle;
    assign in_fire     = s_tvalid && s_tready;
    assign add_en      = in_fire && (s_tuser == tss_pkg::KIND_ADD);
    assign solve_en    = in_fire && (s_tuser == tss_pkg::KIND_SOLVE);
    assign clause_word = {s_tdata[4:0], s_tdata[5], s_tdata[10:6], s_tdata[11]};

    tss_clause_store #(
        .MAX_CLAUSES (MAX_CLAUSES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (add_en),
        .wr_data  (clause_word),
        .clear    (store_clear),
        .rd_addr  (clause_addr),
        .rd_data  (clause_rd),
        .total    (clause_total),
        .overflow (overflow)
    );

    tss_scc_core #(
        .MAX_VARS    (MAX_VARS),
        .MAX_CLAUSES (MAX_CLAUSES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (solve_en),
        .var_count    (var_count_reg),
        .clause_total (clause_total),
        .overflow     (overflow),
        .clause_data  (clause_rd),
        .clause_addr  (clause_addr),
        .store_clear  (store_clear),
        .idle         (idle),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for two_sat_solver: random and directed clause sets are
// loaded and solved, and each per-variable result is compared against an
// SCC-based 2-SAT solution computed in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVARS = 32;
    localparam int NCLS  = 256;
    localparam int NNODE = 2 * NVARS;
    localparam int NONE  = 'hFFFF;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic       kind;
        logic [4:0] a_var;
        logic       a_val;
        logic [4:0] b_var;
        logic       b_val;
    } clause_item_t;

    typedef struct packed {
        logic [4:0] idx;
        logic       value;
        logic       sat;
        logic       ovf;
        logic       last;
    } var_result_t;

    logic clk = 0, rst_n = 0;
    logic cfg_valid = 0, cfg_ready;
    logic [tss_pkg::CNT_W-1:0] cfg_data = '0;
    logic s_tvalid = 0, s_tready, s_tuser = 0;
    logic [tss_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid, m_tready = 0, m_tlast;
    logic [tss_pkg::OUT_DATA_W-1:0] m_tdata;

    two_sat_solver u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial forever #5 clk = ~clk;

    clause_item_t pending_items[$];
    var_result_t  expected_vars[$];
    int  send_idle_pct = 0, recv_stall_pct = 0;
    int  mismatches = 0, results_seen = 0, solves_sent = 0, clauses_sent = 0;
    longint cycles = 0;

    // set at the edge where the current transaction is taken
    logic s_tready_q = 0;

    logic [5:0] phase_counts[7] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd2, 6'd5, 6'd12};

    // solver state mirror
    logic [5:0]  var_count_reg = 6'd32;
    logic [11:0] clause_mem[NCLS];
    int          clause_cnt = 0;
    bit          overflow = 0;

    int fstart[NNODE+1], fdst[2*NCLS], rstart[NNODE+1], rdst[2*NCLS];
    int esrc[2*NCLS], edst[2*NCLS];
    int comp_of[NNODE], fin[NNODE], stk[NNODE], pos[NNODE];
    bit seen[NNODE];

    task automatic queue_item(input clause_item_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic store_clause(input clause_item_t it);
        if (clause_cnt < NCLS)
        begin
            clause_mem[clause_cnt] = {it.a_var, it.a_val, it.b_var, it.b_val};
            clause_cnt++;
        end
        else
            overflow = 1;
    endtask

    task automatic solve_assignment();
        int n, nodes, ne, fill[NNODE], idx, comp, sp, u, e, root;
        bit sat;
        logic [4:0] a, b;
        logic va, vb;
        var_result_t r;
        n = var_count_reg == 0 ? 1 : (var_count_reg > NVARS ? NVARS : var_count_reg);
        nodes = 2 * n;
        ne = 0;
        for (int k = 0; k < clause_cnt; k++)
        begin
            {a, va, b, vb} = clause_mem[k];
            if (a >= n || b >= n) continue;
            esrc[ne] = a + va * n;  edst[ne] = b + (1 - vb) * n;  ne++;
            esrc[ne] = b + vb * n;  edst[ne] = a + (1 - va) * n;  ne++;
        end
        for (int i = 0; i <= NNODE; i++)
        begin
            fstart[i] = 0;
            rstart[i] = 0;
        end
        for (int i = 0; i < ne; i++)
        begin
            fstart[esrc[i]+1]++;
            rstart[edst[i]+1]++;
        end
        for (int i = 0; i < nodes; i++) fstart[i+1] += fstart[i];
        for (int i = 0; i < nodes; i++) fill[i] = fstart[i];
        for (int i = 0; i < ne; i++) fdst[fill[esrc[i]]++] = edst[i];
        for (int i = 0; i < nodes; i++) rstart[i+1] += rstart[i];
        for (int i = 0; i < nodes; i++) fill[i] = rstart[i];
        for (int i = 0; i < ne; i++) rdst[fill[edst[i]]++] = esrc[i];
        for (int i = 0; i < NNODE; i++)
        begin
            seen[i] = 0;
            comp_of[i] = NONE;
        end
        idx = 0;
        for (int i = 0; i < nodes; i++)
        begin
            if (seen[i]) continue;
            seen[i] = 1;
            stk[0] = i; pos[0] = fstart[i]; sp = 1;
            while (sp > 0)
            begin
                u = stk[sp-1];
                if (pos[sp-1] < fstart[u+1])
                begin
                    e = fdst[pos[sp-1]];
                    pos[sp-1]++;
                    if (!seen[e])
                    begin
                        seen[e] = 1;
                        stk[sp] = e; pos[sp] = fstart[e]; sp++;
                    end
                end
                else
                begin
                    sp--;
                    fin[idx++] = u;
                end
            end
        end
        comp = 0;
        for (int i = nodes; i > 0; i--)
        begin
            root = fin[i-1];
            if (comp_of[root] != NONE) continue;
            comp_of[root] = comp;
            stk[0] = root; sp = 1;
            while (sp > 0)
            begin
                sp--;
                u = stk[sp];
                for (int p = rstart[u]; p < rstart[u+1]; p++)
                begin
                    e = rdst[p];
                    if (comp_of[e] == NONE)
                    begin
                        comp_of[e] = comp;
                        stk[sp++] = e;
                    end
                end
            end
            comp++;
        end
        sat = 1;
        for (int i = 0; i < n; i++)
            if (comp_of[i] == comp_of[i+n]) sat = 0;
        for (int i = 0; i < n; i++)
        begin
            r.idx = 5'(i);
            r.value = sat && comp_of[i] > comp_of[i+n];
            r.sat = sat;
            r.ovf = overflow;
            r.last = (i == n - 1);
            expected_vars = {expected_vars, r};
        end
        clause_cnt = 0;
        overflow = 0;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_tready_q)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_items[0].kind;
                    s_tdata  <= {4'b0, pending_items[0].b_val, pending_items[0].b_var,
                                 pending_items[0].a_val, pending_items[0].a_var};
                    void'(pending_items.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        clause_item_t it;
        var_result_t got, want;
        cycles++;
        s_tready_q <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            it.kind = s_tuser;
            {it.b_val, it.b_var, it.a_val, it.a_var} = s_tdata[11:0];
            if (it.kind == tss_pkg::KIND_ADD)
            begin
                store_clause(it);
                clauses_sent++;
            end
            else
            begin
                solve_assignment();
                solves_sent++;
            end
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[4:0], m_tdata[5], m_tdata[6], m_tdata[7], m_tlast};
            results_seen++;
            if (expected_vars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_vars.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected idx=%0d val=%b sat=%b ovf=%b last=%b,",
                                  " got idx=%0d val=%b sat=%b ovf=%b last=%b"},
                                 want.idx, want.value, want.sat, want.ovf, want.last,
                                 got.idx, got.value, got.sat, got.ovf, got.last);
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic clause_item_t rand_clause(int n);
        clause_item_t c;
        c.kind = tss_pkg::KIND_ADD;
        c.a_var = 5'($urandom_range(n - 1));
        c.b_var = 5'($urandom_range(n - 1));
        c.a_val = 1'($urandom);
        c.b_val = 1'($urandom);
        if ($urandom_range(9) == 0) c.a_var = 5'($urandom);
        return c;
    endfunction

    function automatic clause_item_t solve_item();
        clause_item_t c;
        c = 12'($urandom);
        c.kind = tss_pkg::KIND_SOLVE;
        return c;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_vars.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_var_count(input logic [5:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        var_count_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int n;
        clause_item_t c;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, contradiction, overflow, default count
        c = '{tss_pkg::KIND_ADD, 5'd0, 1'b1, 5'd31, 1'b0};  queue_item(c);
        c = '{tss_pkg::KIND_ADD, 5'd31, 1'b1, 5'd31, 1'b1}; queue_item(c);
        c = '{tss_pkg::KIND_ADD, 5'd31, 1'b0, 5'd31, 1'b0}; queue_item(c);
        queue_item(solve_item());
        queue_item(solve_item());
        c = '{tss_pkg::KIND_ADD, 5'd3, 1'b0, 5'd4, 1'b1};   queue_item(c);
        queue_item(solve_item());
        drain();
        write_var_count(6'd4);
        for (int i = 0; i < 260; i++)
        begin
            c = rand_clause(4);
            c.a_var = 0; c.b_var = 1;
            queue_item(c);
        end
        queue_item(solve_item());
        c = '{tss_pkg::KIND_ADD, 5'd21, 1'b1, 5'd10, 1'b0}; queue_item(c);
        queue_item(solve_item());
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            write_var_count(phase_counts[ph % 7]);
            n = var_count_reg == 0 ? 1 : (var_count_reg > NVARS ? NVARS : var_count_reg);
            for (int s = 0; s < 3; s++)
            begin
                for (int k = $urandom_range(6); k > 0; k--)
                    queue_item(rand_clause(n));
                queue_item(solve_item());
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        $display("tb: %0d clauses, %0d solves, %0d results; var counts 0..63 and overflow covered",
                 clauses_sent, solves_sent, results_seen);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

`default_nettype wire

### two_sat_solver.f
+incdir+design
design/tss_pkg.sv
design/tss_clause_store.sv
design/tss_edge_unit.sv
design/tss_scc_core.sv
design/two_sat_solver.sv
tb/tb.sv
